@@ src/tbhc_pkg.sv @@
package tbhc_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned ErrW = DataW + 1;
  localparam int unsigned AccW = 33;
  localparam int unsigned MulAW = AccW;
  localparam int unsigned MulBW = DataW + 1;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned SumW = 42;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGain = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStep = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMin = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMax = 3'd4;

  localparam logic [1:0] SignZero = 2'd0;
  localparam logic [1:0] SignPos = 2'd1;
  localparam logic [1:0] SignNeg = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GAIN,
    ST_MUL_STEP,
    ST_CLAMP,
    ST_FINISH
  } state_e;

  typedef enum logic {
    MUL_ERR_GAIN,
    MUL_PROD_STEP
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     clamp_en;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ src/tbhc_ctrl.sv @@
module tbhc_ctrl
  import tbhc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   take_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = !((state_q == ST_IDLE) ||
                        ((state_q == ST_FINISH) && status_i.out_free));
  assign take_w = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL_GAIN;
        end
      end
      ST_MUL_GAIN: begin
        state_d = ST_MUL_STEP;
      end
      ST_MUL_STEP: begin
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = in_valid_i ? ST_MUL_GAIN : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.load = take_w;
    cmd_o.mul_en = 1'b0;
    cmd_o.mul_sel = MUL_ERR_GAIN;
    cmd_o.clamp_en = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      ST_MUL_GAIN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_ERR_GAIN;
      end
      ST_MUL_STEP: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MUL_PROD_STEP;
      end
      ST_CLAMP: begin
        cmd_o.clamp_en = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o.mul_en = 1'b0;
      end
    endcase
  end

endmodule

@@ src/tbhc_dp.sv @@
module tbhc_dp
  import tbhc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [DataW-1:0]          cfg_data_i,
  input  logic signed [DataW-1:0]   measured_value_i,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DataW-1:0]   drive_value_o,
  output logic                      crossed_o
);

  logic signed [DataW-1:0] target_q;
  logic [DataW-1:0]        gain_q;
  logic [DataW-1:0]        step_q;
  logic signed [DataW-1:0] min_q;
  logic signed [DataW-1:0] max_q;

  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  held_q;
  logic [1:0]              last_sign_q;

  logic signed [ErrW-1:0]  err_d, err_q;
  logic [1:0]              sign_d, sign_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  clamp_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  logic signed [SumW-1:0]  sum_w;
  logic signed [SumW-1:0]  hi_w;
  logic signed [SumW-1:0]  lo_w;
  logic signed [SumW-1:0]  upper_w;
  logic signed [SumW-1:0]  lim_w;

  logic signed [AccW:0]    avg_sum;
  logic                    crossed_w;

  logic                    out_valid_q;
  logic signed [DataW-1:0] drive_q;
  logic                    crossed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      gain_q <= '0;
      step_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTarget: target_q <= cfg_data_i;
        CfgGain:   gain_q <= cfg_data_i;
        CfgStep:   step_q <= cfg_data_i;
        CfgMin:    min_q <= cfg_data_i;
        CfgMax:    max_q <= cfg_data_i;
        default:   target_q <= target_q;
      endcase
    end
  end

  assign err_d = {target_q[DataW-1], target_q} - {measured_value_i[DataW-1], measured_value_i};

  always_comb begin
    if (err_d == '0) begin
      sign_d = SignZero;
    end else if (err_d[ErrW-1]) begin
      sign_d = SignNeg;
    end else begin
      sign_d = SignPos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= err_d;
      sign_q <= sign_d;
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ERR_GAIN: begin
        mul_a = {{(MulAW-ErrW){err_q[ErrW-1]}}, err_q};
        mul_b = {1'b0, gain_q};
      end
      MUL_PROD_STEP: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = {1'b0, step_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
  end

  assign sum_w = {{(SumW-AccW){acc_q[AccW-1]}}, acc_q} + prod_q[ProdW-1:8];
  assign hi_w = {{(SumW-2*DataW){max_q[DataW-1]}}, max_q, {DataW{1'b0}}};
  assign lo_w = {{(SumW-2*DataW){min_q[DataW-1]}}, min_q, {DataW{1'b0}}};
  assign upper_w = (sum_w > hi_w) ? hi_w : sum_w;
  assign lim_w = (upper_w < lo_w) ? lo_w : upper_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp_en) begin
      clamp_q <= lim_w[AccW-1:0];
    end
  end

  assign crossed_w = (sign_q != last_sign_q);
  assign avg_sum = {clamp_q[AccW-1], clamp_q} + {held_q[AccW-1], held_q};
  assign acc_d = crossed_w ? avg_sum[AccW:1] : clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      held_q <= '0;
      last_sign_q <= SignZero;
    end else if (cmd_i.commit) begin
      acc_q <= acc_d;
      if (crossed_w) begin
        held_q <= acc_d;
        last_sign_q <= sign_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      drive_q <= acc_d[2*DataW-1:DataW];
      crossed_q <= crossed_w;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign drive_value_o = drive_q;
  assign crossed_o = crossed_q;

endmodule

@@ src/take_back_half_controller.sv @@
// Take-back-half drive regulator.
// The input channel carries one measured sample per item on in_valid_i and
// measured_value_i; the block holds in_stall_o high while it works on an item.
// Each item yields exactly one result item on out_valid_o with drive_value_o,
// the integer part of the updated drive, and crossed_o, which is high when a
// change of error sign halved the drive toward the held value.
// Registers are written through cfg_valid_i, cfg_index_i and cfg_data_i; the
// port is always ready and writes are expected only while the block is idle.
// After an item is accepted, the block forms the two products in turn on the
// shared multiplier, then does the accumulate and clamp, and then the
// take-back-half step into the output register.
// The next item is taken in that final step, as the result is committed, and
// not before, so the item rate is set by the walk through the shared multiplier.
// When the receiver stalls, the result waits in the output register; a second
// finished item waits in the final step until the register empties.
// Reset clears the configuration, the drive, the held drive and the recorded
// sign, and leaves no result pending.
module take_back_half_controller
  import tbhc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] measured_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] drive_value_o,
  output logic                    crossed_o
);

  cmd_t    cmd_w;
  status_t status_w;

  assign cfg_ready_o = 1'b1;

  tbhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status_w),
    .cmd_o      (cmd_w)
  );

  tbhc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .measured_value_i (measured_value_i),
    .cmd_i            (cmd_w),
    .status_o         (status_w),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_value_o    (drive_value_o),
    .crossed_o        (crossed_o)
  );

endmodule

@@ bench/take_back_half_controller_tb.sv @@
`timescale 1ns / 100ps

module take_back_half_controller_tb;
  import tbhc_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    crossed;
  } drive_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [DataW-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [DataW-1:0] measured_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [DataW-1:0] drive_value_o;
  logic                    crossed_o;

  logic signed [DataW-1:0] target_q;
  logic [DataW-1:0]        gain_q;
  logic [DataW-1:0]        step_q;
  logic signed [DataW-1:0] min_q;
  logic signed [DataW-1:0] max_q;
  longint                  drive_acc;
  longint                  held_drive;
  logic [1:0]              last_sign;

  drive_result_t           drive_q[$];
  drive_result_t           due;
  logic                    calm_run;
  int                      mismatch_count = 0;
  int                      samples_sent;
  int                      results_checked = 0;
  int                      crossings_seen = 0;
  int                      settings_used;

  take_back_half_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .measured_value_i(measured_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_value_o   (drive_value_o),
    .crossed_o       (crossed_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic drive_result_t advance_drive(input logic signed [DataW-1:0] meas);
    longint        err;
    longint        acc;
    longint        acc_hi;
    longint        acc_lo;
    longint        whole;
    logic [1:0]    sgn;
    drive_result_t r;
    err = longint'(target_q) - longint'(meas);
    acc = drive_acc + ((err * longint'(gain_q) * longint'(step_q)) >>> 8);
    acc_hi = longint'(max_q) * 65536;
    acc_lo = longint'(min_q) * 65536;
    if (acc > acc_hi) acc = acc_hi;
    if (acc < acc_lo) acc = acc_lo;
    sgn = (err > 0) ? SignPos : ((err < 0) ? SignNeg : SignZero);
    r.crossed = 1'b0;
    if (sgn != last_sign) begin
      acc = (acc + held_drive) >>> 1;
      held_drive = acc;
      last_sign = sgn;
      r.crossed = 1'b1;
    end
    drive_acc = acc;
    whole = acc >>> 16;
    r.drive = whole[DataW-1:0];
    return r;
  endfunction

  task automatic send_sample(input logic signed [DataW-1:0] meas);
    @(negedge clk_i);
    while (!calm_run && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_value_i <= meas;
    do @(posedge clk_i); while (in_stall_o);
    drive_q.push_back(advance_drive(meas));
    samples_sent++;
  endtask

  task automatic settle_block;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgTarget: target_q = data;
      CfgGain:   gain_q = data;
      CfgStep:   step_q = data;
      CfgMin:    min_q = data;
      CfgMax:    max_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(input logic [DataW-1:0] target, input logic [DataW-1:0] gain,
                               input logic [DataW-1:0] step, input logic [DataW-1:0] lo,
                               input logic [DataW-1:0] hi);
    settle_block();
    write_register(CfgTarget, target);
    write_register(CfgGain, gain);
    write_register(CfgStep, step);
    write_register(CfgMin, lo);
    write_register(CfgMax, hi);
    settings_used++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !calm_run && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got drive_value %0d crossed %0b",
                 $time, drive_value_o, crossed_o);
        mismatch_count++;
      end else begin
        due = drive_q.pop_front();
        if (drive_value_o !== due.drive) begin
          $display("%0t: drive_value expected %0d, got %0d", $time, due.drive, drive_value_o);
          mismatch_count++;
        end
        if (crossed_o !== due.crossed) begin
          $display("%0t: crossed expected %0b, got %0b", $time, due.crossed, crossed_o);
          mismatch_count++;
        end
        results_checked++;
        if (due.crossed) crossings_seen++;
      end
    end
  end

  task automatic check_reset_state;
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
  endtask

  task automatic check_full_scale;
    load_settings(16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd32767);
    load_settings(16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_sample(16'sd32767);
    load_settings(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_sample(-16'sd32768);
  endtask

  task automatic check_inverted_range;
    load_settings(16'd50, 16'h0100, 16'h8000, 16'd100, -16'sd100);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd200);
    send_sample(-16'sd300);
  endtask

  task automatic check_zero_increment;
    load_settings(16'd10, 16'h0000, 16'hFFFF, -16'sd1000, 16'd1000);
    send_sample(16'sd10);
    send_sample(16'sd0);
    send_sample(16'sd20);
    send_sample(16'sd10);
    load_settings(16'd10, 16'h4000, 16'h0000, -16'sd1000, 16'd1000);
    send_sample(16'sd0);
    send_sample(16'sd20);
  endtask

  task automatic check_unused_index;
    settle_block();
    for (int k = 1; k <= 3; k++) begin
      write_register(CfgMax + 3'(k), 16'($urandom));
    end
    for (int k = 0; k < 3; k++) begin
      send_sample(16'($urandom));
    end
  endtask

  task automatic run_random_sweeps;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic signed [DataW-1:0] lo;
    logic signed [DataW-1:0] hi;
    logic [DataW-1:0]        gain;
    logic [DataW-1:0]        step;
    logic signed [DataW-1:0] target;
    int                      spread;
    int                      v;
    for (int phase = 0; phase < 8; phase++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(5))
        0: begin
          lo = -16'sd32768;
          hi = 16'sd32767;
        end
        1: begin
          lo = a;
          hi = a;
        end
        5: begin
          lo = (a > b) ? a : b;
          hi = (a > b) ? b : a;
        end
        default: begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
      endcase
      case ($urandom_range(4))
        0: gain = 16'hFFFF;
        1: gain = 16'($urandom_range(1, 255));
        2: gain = 16'h0000;
        default: gain = 16'($urandom);
      endcase
      case ($urandom_range(4))
        0: step = 16'hFFFF;
        1: step = 16'($urandom_range(1, 255));
        2: step = 16'h0000;
        default: step = 16'($urandom);
      endcase
      case ($urandom_range(4))
        0: target = -16'sd32768;
        1: target = 16'sd32767;
        default: target = 16'($urandom);
      endcase
      if (phase == 0) begin
        lo = -16'sd32768;
        hi = 16'sd32767;
        gain = 16'hFFFF;
        step = 16'hFFFF;
      end
      load_settings(target, gain, step, lo, hi);
      calm_run = (phase == 3);
      case ($urandom_range(3))
        0: spread = 0;
        1: spread = 4;
        2: spread = 64;
        default: spread = 4096;
      endcase
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(99) < 70) begin
          v = int'(target_q) + int'($urandom_range(0, 2 * spread)) - spread;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          send_sample(16'(v));
        end else begin
          send_sample(16'($urandom));
        end
      end
      calm_run = 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgTarget;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    measured_value_i = '0;
    calm_run = 1'b0;
    target_q = '0;
    gain_q = '0;
    step_q = '0;
    min_q = '0;
    max_q = '0;
    drive_acc = 0;
    held_drive = 0;
    last_sign = SignZero;
    samples_sent = 0;
    settings_used = 1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_reset_state();
    check_full_scale();
    check_inverted_range();
    check_zero_increment();
    check_unused_index();
    run_random_sweeps();
    settle_block();

    $display(
      "Sent %0d samples under %0d register settings, including inverted and zero-width ranges.",
      samples_sent, settings_used);
    $display("Checked %0d results, %0d of them with a take-back-half step.",
             results_checked, crossings_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("%0t: timed out with %0d results outstanding", $time, drive_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
src/tbhc_pkg.sv
src/tbhc_ctrl.sv
src/tbhc_dp.sv
src/take_back_half_controller.sv
bench/take_back_half_controller_tb.sv
